FILE: design/obb_obb_overlap_test_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle overlap tester
// Checks compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef OBB_OBB_OVERLAP_TEST_ASSERT_SVH
`define OBB_OBB_OVERLAP_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define OBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OBB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OBB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OBB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared constants and helpers for the rectangle overlap tester.
// ----------------------------------------------------------------------------
package obb_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int ZW = 32;
    localparam int XW = 34;
    localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            4'd0: v = 32'sh20000000;
            4'd1: v = 32'sh12E4051D;
            4'd2: v = 32'sh09FB385B;
            4'd3: v = 32'sh051111D4;
            4'd4: v = 32'sh028B0D43;
            4'd5: v = 32'sh0145D7E1;
            4'd6: v = 32'sh00A2F61E;
            4'd7: v = 32'sh00517C55;
            4'd8: v = 32'sh0028BE53;
            4'd9: v = 32'sh00145F2E;
            4'd10: v = 32'sh000A2F98;
            4'd11: v = 32'sh000517CC;
            4'd12: v = 32'sh00028BE6;
            4'd13: v = 32'sh000145F3;
            4'd14: v = 32'sh0000A2F9;
            default: v = 32'sh0000517C;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] rnd_sat15(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767) return 16'sd32767;
        if (r < -34'sd32767) return -16'sd32767;
        return r[15:0];
    endfunction
endpackage

FILE: design/obb_cordic.sv
// ----------------------------------------------------------------------------
// obb_cordic
// Pipelined sine/cosine: one CORDIC iteration per stage, quadrant fix at end.
// ----------------------------------------------------------------------------
module obb_cordic import obb_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output logic signed [15:0]    o_sin,
    output logic signed [15:0]    o_cos
);
    logic signed [XW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [XW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [ZW:0]   r_z [CORDIC_STEPS+1];
    logic [1:0]           r_q [CORDIC_STEPS+1];
    logic [31:0]          phase;

    assign phase = {i_angle, {(32-ANGLE_BITS){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_X0;
            r_y[0] <= '0;
            r_z[0] <= {3'b000, phase[29:0]};
            r_q[0] <= phase[31:30];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
        logic signed [XW-1:0] dx, dy;
        logic signed [ZW:0]   at;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        assign at = (ZW+1)'(atan_lut(4'(i)));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i+1] <= r_q[i];
                if (!r_z[i][ZW]) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - at;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + at;
                end
            end
        end
    end

    logic signed [15:0] c, s;
    assign c = rnd_sat15(r_x[CORDIC_STEPS]);
    assign s = rnd_sat15(r_y[CORDIC_STEPS]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r_q[CORDIC_STEPS])
                2'd0: begin o_cos <= c;  o_sin <= s;  end
                2'd1: begin o_cos <= -s; o_sin <= c;  end
                2'd2: begin o_cos <= -c; o_sin <= -s; end
                default: begin o_cos <= s; o_sin <= -c; end
            endcase
        end
    end
endmodule

FILE: design/obb_corners.sv
// ----------------------------------------------------------------------------
// obb_corners
// Rotate half extents and place the four corners about the centre.
// ----------------------------------------------------------------------------
module obb_corners import obb_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic [COORD_BITS-2:0]        i_hw,
    input  logic [COORD_BITS-2:0]        i_hh,
    input  logic signed [15:0]           i_sin,
    input  logic signed [15:0]           i_cos,
    output logic signed [COORD_BITS+1:0] o_px [4],
    output logic signed [COORD_BITS+1:0] o_py [4]
);
    localparam int PW = COORD_BITS + 16;
    localparam int CW = COORD_BITS + 2;
    logic signed [PW-1:0] r_wc, r_ws, r_hc, r_hs;
    logic signed [COORD_BITS-1:0] r_cx, r_cy;
    logic signed [COORD_BITS:0] hw_s, hh_s;

    assign hw_s = $signed({2'b00, i_hw});
    assign hh_s = $signed({2'b00, i_hh});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wc <= PW'(hw_s * i_cos);
            r_ws <= PW'(hw_s * i_sin);
            r_hc <= PW'(hh_s * i_cos);
            r_hs <= PW'(hh_s * i_sin);
            r_cx <= i_cx;
            r_cy <= i_cy;
        end
    end

    localparam logic [3:0] SGX_NEG = 4'b1001;
    localparam logic [3:0] SGY_NEG = 4'b0011;

    for (genvar k = 0; k < 4; k++) begin : g_k
        logic signed [PW:0] wc, ws, hc, hs, ox, oy;
        assign wc = SGX_NEG[k] ? -(PW+1)'(r_wc) : (PW+1)'(r_wc);
        assign ws = SGX_NEG[k] ? -(PW+1)'(r_ws) : (PW+1)'(r_ws);
        assign hc = SGY_NEG[k] ? -(PW+1)'(r_hc) : (PW+1)'(r_hc);
        assign hs = SGY_NEG[k] ? -(PW+1)'(r_hs) : (PW+1)'(r_hs);
        assign ox = (wc - hs + (PW+1)'(16384)) >>> 15;
        assign oy = (ws + hc + (PW+1)'(16384)) >>> 15;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                o_px[k] <= CW'(r_cx) + CW'(ox);
                o_py[k] <= CW'(r_cy) + CW'(oy);
            end
        end
    end
endmodule

FILE: design/obb_project.sv
// ----------------------------------------------------------------------------
// obb_project
// Project all corners onto four axes, min/max trees, interval compare.
// ----------------------------------------------------------------------------
module obb_project import obb_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS+1:0] i_px [2][4],
    input  logic signed [COORD_BITS+1:0] i_py [2][4],
    input  logic signed [15:0]           i_sin [2],
    input  logic signed [15:0]           i_cos [2],
    output logic                         o_hit
);
    localparam int VW = COORD_BITS + 19;
    logic signed [VW-1:0] r_v [4][2][4];
    logic signed [VW-1:0] r_lo [4][2];
    logic signed [VW-1:0] r_hi [4][2];
    logic                 n_hit;

    for (genvar a = 0; a < 4; a++) begin : g_a
        logic signed [15:0] ux, uy;
        assign ux = ((a % 2) != 0) ? -i_sin[a/2] : i_cos[a/2];
        assign uy = ((a % 2) != 0) ? i_cos[a/2] : i_sin[a/2];
        for (genvar b = 0; b < 2; b++) begin : g_b
            logic signed [VW-1:0] n_lo;
            logic signed [VW-1:0] n_hi;
            for (genvar k = 0; k < 4; k++) begin : g_k
                always_ff @(posedge i_clk) begin
                    if (i_en) r_v[a][b][k] <= VW'(i_px[b][k] * ux) + VW'(i_py[b][k] * uy);
                end
            end
            always_comb begin
                logic signed [VW-1:0] lo, hi;
                lo = r_v[a][b][0];
                hi = r_v[a][b][0];
                for (int k = 1; k < 4; k++) begin
                    if (r_v[a][b][k] < lo) lo = r_v[a][b][k];
                    if (r_v[a][b][k] > hi) hi = r_v[a][b][k];
                end
                n_lo = lo;
                n_hi = hi;
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_lo[a][b] <= n_lo;
                    r_hi[a][b] <= n_hi;
                end
            end
        end
    end

    always_comb begin
        n_hit = 1'b1;
        for (int a = 0; a < 4; a++)
            if (r_hi[a][0] < r_lo[a][1] || r_hi[a][1] < r_lo[a][0]) n_hit = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_hit <= n_hit;
    end
endmodule

FILE: design/obb_obb_overlap_test.sv
// ----------------------------------------------------------------------------
// obb_obb_overlap_test
// Oriented rectangle overlap test by separating axes, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_stall with the two rectangles as separate ports.
// Output channel: o_valid/i_stall with the single bit o_hit.
// While the output is not stalled, one item enters per cycle; throughput is one item per cycle.
// The pipeline runs the CORDIC (load, 16 iterations, quadrant fix), then
// corner rotation (products, corners), then projection, min/max, compare.
// The whole pipeline advances only when the output is not stalled;
// o_stall follows i_stall while the output holds an item.
// A stall freezes every stage in place, so nothing is lost or repeated.
// Synchronous active-low reset clears the valid bits; data is not reset.
// ----------------------------------------------------------------------------
`include "obb_obb_overlap_test_assert.svh"
module obb_obb_overlap_test import obb_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_first_x,
    input  logic signed [COORD_BITS-1:0] i_first_y,
    input  logic [COORD_BITS-2:0]        i_first_half_w,
    input  logic [COORD_BITS-2:0]        i_first_half_h,
    input  logic [ANGLE_BITS-1:0]        i_first_angle,
    input  logic signed [COORD_BITS-1:0] i_second_x,
    input  logic signed [COORD_BITS-1:0] i_second_y,
    input  logic [COORD_BITS-2:0]        i_second_half_w,
    input  logic [COORD_BITS-2:0]        i_second_half_h,
    input  logic [ANGLE_BITS-1:0]        i_second_angle,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit
);
    localparam int CLAT = CORDIC_STEPS + 2;
    localparam int LAT = CLAT + 5;

    logic en;
    logic [LAT-1:0] r_vld;
    assign en = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[LAT-2:0], i_valid};
    end

    logic signed [COORD_BITS-1:0] r_cx [CLAT][2];
    logic signed [COORD_BITS-1:0] r_cy [CLAT][2];
    logic [COORD_BITS-2:0]        r_hw [CLAT][2];
    logic [COORD_BITS-2:0]        r_hh [CLAT][2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0][0] <= i_first_x;  r_cx[0][1] <= i_second_x;
            r_cy[0][0] <= i_first_y;  r_cy[0][1] <= i_second_y;
            r_hw[0][0] <= i_first_half_w;  r_hw[0][1] <= i_second_half_w;
            r_hh[0][0] <= i_first_half_h;  r_hh[0][1] <= i_second_half_h;
            for (int s = 1; s < CLAT; s++) begin
                r_cx[s] <= r_cx[s-1];
                r_cy[s] <= r_cy[s-1];
                r_hw[s] <= r_hw[s-1];
                r_hh[s] <= r_hh[s-1];
            end
        end
    end

    logic signed [15:0] sn [2];
    logic signed [15:0] cs [2];
    logic signed [15:0] r_sn [2][2];
    logic signed [15:0] r_cs [2][2];
    logic signed [COORD_BITS+1:0] px [2][4];
    logic signed [COORD_BITS+1:0] py [2][4];

    obb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic0 (
        .i_clk(i_clk), .i_en(en), .i_angle(i_first_angle), .o_sin(sn[0]), .o_cos(cs[0]));
    obb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic1 (
        .i_clk(i_clk), .i_en(en), .i_angle(i_second_angle), .o_sin(sn[1]), .o_cos(cs[1]));

    for (genvar b = 0; b < 2; b++) begin : g_box
        obb_corners #(.COORD_BITS(COORD_BITS)) u_corners (
            .i_clk(i_clk), .i_en(en),
            .i_cx(r_cx[CLAT-1][b]), .i_cy(r_cy[CLAT-1][b]),
            .i_hw(r_hw[CLAT-1][b]), .i_hh(r_hh[CLAT-1][b]),
            .i_sin(sn[b]), .i_cos(cs[b]),
            .o_px(px[b]), .o_py(py[b]));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sn[0] <= sn; r_cs[0] <= cs;
            r_sn[1] <= r_sn[0]; r_cs[1] <= r_cs[0];
        end
    end

    obb_project #(.COORD_BITS(COORD_BITS)) u_project (
        .i_clk(i_clk), .i_en(en), .i_px(px), .i_py(py),
        .i_sin(r_sn[1]), .i_cos(r_cs[1]), .o_hit(o_hit));

    `OBB_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `OBB_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `OBB_ASSERT_NXT(a_advance, i_clk, i_rst_n, !o_stall, r_vld[0] == $past(i_valid))
endmodule

FILE: tb/tb_obb_obb_overlap_test.sv
// ----------------------------------------------------------------------------
// tb_obb_obb_overlap_test
// Streams random and directed rectangle pairs through the overlap tester,
// predicts each hit bit with an independent separating-axis model and
// checks results in order under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_obb_obb_overlap_test;
    localparam int CB = 16;
    localparam int AB = 16;
    localparam int N_RANDOM = 1430;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic [CB-2:0]        hw;
        logic [CB-2:0]        hh;
        logic [AB-1:0]        ang;
    } t_rect;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_hit;
    logic signed [CB-1:0] i_first_x = '0, i_first_y = '0, i_second_x = '0, i_second_y = '0;
    logic [CB-2:0] i_first_half_w = '0, i_first_half_h = '0;
    logic [CB-2:0] i_second_half_w = '0, i_second_half_h = '0;
    logic [AB-1:0] i_first_angle = '0, i_second_angle = '0;

    bit quiet_tail = 1'b0;
    bit hold_out = 1'b0;

    always #5 i_clk = ~i_clk;

    obb_obb_overlap_test #(.COORD_BITS(CB), .ANGLE_BITS(AB)) i_dut (.*);

    function automatic longint asr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q15(longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic longint clamp_q15(longint v);
        if (v > 32767) return 32767;
        if (v < -32767) return -32767;
        return v;
    endfunction

    function automatic void rotor(input logic [AB-1:0] ang, output longint sn,
                                  output longint cs);
        longint arc [16] = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
                             64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                             64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
                             64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};
        logic [31:0] ph;
        longint x, y, z, dx, dy, c, s;
        ph = {ang, {(32-AB){1'b0}}};
        z = longint'(ph[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = asr_floor(y, i);
            dy = asr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= arc[i];
            end else begin
                x += dx; y -= dy; z += arc[i];
            end
        end
        c = clamp_q15(round_q15(x));
        s = clamp_q15(round_q15(y));
        case (ph[31:30])
            2'd0: begin cs = c;  sn = s;  end
            2'd1: begin cs = -s; sn = c;  end
            2'd2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
    endfunction

    function automatic bit boxes_overlap(t_rect r [2]);
        int sgx [4] = '{-1, 1, 1, -1};
        int sgy [4] = '{-1, -1, 1, 1};
        longint px [2][4], py [2][4], sn [2], cs [2];
        longint hx, hy, ux, uy, v, lo [2], hi [2];
        bit hit;
        for (int b = 0; b < 2; b++) begin
            rotor(r[b].ang, sn[b], cs[b]);
            for (int k = 0; k < 4; k++) begin
                hx = sgx[k] * longint'(r[b].hw);
                hy = sgy[k] * longint'(r[b].hh);
                px[b][k] = longint'(r[b].cx) + round_q15(hx * cs[b] - hy * sn[b]);
                py[b][k] = longint'(r[b].cy) + round_q15(hx * sn[b] + hy * cs[b]);
            end
        end
        hit = 1'b1;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                ux = j ? -sn[i] : cs[i];
                uy = j ? cs[i] : sn[i];
                for (int b = 0; b < 2; b++) begin
                    for (int k = 0; k < 4; k++) begin
                        v = px[b][k] * ux + py[b][k] * uy;
                        if (k == 0 || v < lo[b]) lo[b] = v;
                        if (k == 0 || v > hi[b]) hi[b] = v;
                    end
                end
                if (hi[0] < lo[1] || hi[1] < lo[0]) hit = 1'b0;
            end
        end
        return hit;
    endfunction

    class hit_scoreboard;
        bit pending_hits [$];
        int errors = 0;

        function void note_pair(t_rect r [2]);
            pending_hits.push_back(boxes_overlap(r));
        endfunction

        function void check_hit(logic hit);
            bit want;
            if (pending_hits.size() == 0) begin
                $error("unexpected result: hit=%0b", hit);
                errors++;
                return;
            end
            want = pending_hits.pop_front();
            if (hit !== want) begin
                $error("hit mismatch: expected %0b, actual %0b", want, hit);
                errors++;
            end
        endfunction
    endclass

    hit_scoreboard sb = new();

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_hit(o_hit);
    end

    // output back-pressure
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                i_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 13);
                i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_pair(t_rect r [2]);
        int n;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(negedge i_clk);
        end
        i_first_x <= r[0].cx; i_first_y <= r[0].cy;
        i_first_half_w <= r[0].hw; i_first_half_h <= r[0].hh;
        i_first_angle <= r[0].ang;
        i_second_x <= r[1].cx; i_second_y <= r[1].cy;
        i_second_half_w <= r[1].hw; i_second_half_h <= r[1].hh;
        i_second_angle <= r[1].ang;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_pair(r);
        @(negedge i_clk);
    endtask

    function automatic t_rect rand_rect(bit near);
        t_rect r;
        int span;
        span = near ? 2048 : 32767;
        r.cx = near ? CB'($urandom_range(0, 2 * span) - span) : CB'($urandom);
        r.cy = near ? CB'($urandom_range(0, 2 * span) - span) : CB'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                r.hw = (CB-1)'($urandom_range(0, 15));
                r.hh = (CB-1)'($urandom_range(0, 15));
            end
            1: begin r.hw = (CB-1)'($urandom); r.hh = (CB-1)'($urandom); end
            default: begin
                r.hw = (CB-1)'($urandom_range(0, 1500));
                r.hh = (CB-1)'($urandom_range(0, 1500));
            end
        endcase
        r.ang = AB'($urandom);
        return r;
    endfunction

    task automatic directed_set();
        t_rect r [2];
        logic [AB-1:0] angs [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'hFFFF};
        for (int a = 0; a < 6; a++) begin
            r[0] = '{0, 0, 160, 80, angs[a]};
            r[1] = '{16'sd320, 0, 160, 80, angs[5 - a]};
            send_pair(r);
        end
        // touching edges, separated by one lsb, zero-area, points
        r[0] = '{0, 0, 16, 16, 0}; r[1] = '{32, 0, 16, 16, 0}; send_pair(r);
        r[1] = '{33, 0, 16, 16, 0}; send_pair(r);
        r[0] = '{0, 0, 0, 0, 0}; r[1] = '{0, 0, 0, 0, 0}; send_pair(r);
        r[1] = '{1, 0, 0, 0, 0}; send_pair(r);
        r[0] = '{-5, 0, 100, 0, 16'h1234}; r[1] = '{0, 0, 0, 100, 16'h1234}; send_pair(r);
        r[0] = '{16'sh7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF, 16'hFFFF};
        r[1] = '{16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF, 16'h0001}; send_pair(r);
        r[0] = '{16'sh8000, 16'sh7FFF, 15'h7FFF, 0, 16'h8000};
        r[1] = '{16'sh7FFF, 16'sh8000, 0, 15'h7FFF, 16'h4000}; send_pair(r);
        r[0] = '{16'sh7FFF, 16'sh8000, 15'h5555, 15'h2AAA, 16'hAAAA};
        r[1] = '{16'sh8000, 16'sh7FFF, 15'h2AAA, 15'h5555, 16'h5555}; send_pair(r);
        r[0] = '{0, 0, 15'h7FFF, 15'h7FFF, 16'h2000};
        r[1] = '{0, 0, 1, 1, 16'h6000}; send_pair(r);
    endtask

    initial begin
        t_rect r [2];
        int guard;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        directed_set();
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) begin
                hold_out = 1'b1;
                fork
                    begin repeat (80) @(negedge i_clk); hold_out = 1'b0; end
                join_none
            end
            if (n == 700) begin
                i_valid <= 1'b0;
                while (sb.pending_hits.size() != 0) @(negedge i_clk);
            end
            if (n == N_RANDOM - 150) quiet_tail = 1'b1;
            r[0] = rand_rect($urandom_range(0, 3) != 0);
            r[1] = r[0];
            if ($urandom_range(0, 3) != 0) begin
                r[1] = rand_rect(1'b1);
                r[1].cx = r[0].cx + CB'($urandom_range(0, 800) - 400);
                r[1].cy = r[0].cy + CB'($urandom_range(0, 800) - 400);
            end else begin
                r[1] = rand_rect($urandom_range(0, 1) != 0);
            end
            send_pair(r);
        end
        i_valid <= 1'b0;
        guard = 0;
        while (sb.pending_hits.size() != 0 && guard < 10000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+design
design/obb_pkg.sv
design/obb_cordic.sv
design/obb_corners.sv
design/obb_project.sv
design/obb_obb_overlap_test.sv
tb/tb_obb_obb_overlap_test.sv
